[rtl/assert_macros.svh]
// Assertion macros for the RTL that checks its own behavior.
// Depends on nothing; the macros expect i_clk in scope, and QPED_ASSERT also i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define QPED_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("query decoder assertion failed");

// Checked at every clock edge, reset included.
`define QPED_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("query decoder assertion failed during reset");

`endif

[rtl/qped_pkg.sv]
// Types and constants shared by the query parameter decoder modules.
// Depends on nothing.
package qped_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc;

    typedef struct packed {
        logic       has_byte;
        t_kind      kind;
        logic [7:0] data;
        logic       has_end;
        logic       found;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

[rtl/query_param_extract_decode.sv]
// Top level of the query string parameter decoder: register port and wiring.
// Depends on qped_pkg, qped_front, qped_queue, qped_back and assert_macros.svh.
//
// The block takes one raw byte of a form-encoded query string per transaction
// and emits the URL-decoded name and value bytes of the parameter whose
// position equals target_index, followed on the last byte by an end item
// that reports whether that parameter exists. A new byte is accepted every
// cycle while the four-entry result queue has room. Results leave through a
// single output register at one per cycle while i_out_stall is low, so the
// decoded byte and the end item of one input byte leave one after the other.
// Results pass through the result queue and then the output register.
// target_index is register 0 at address 0 of the configuration port; the user
// must write it only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module query_param_extract_decode
    import qped_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_item_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_param_found,
    output logic        o_out_last
);

    localparam logic REG_TARGET_INDEX = 1'b0;

    logic [7:0] r_target_index;
    logic       push;
    logic       pop;
    t_job       front_job;
    t_job       head_job;
    t_qstat     qstat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TARGET_INDEX) ? {24'h000000, r_target_index} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_index <= 8'h00;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET_INDEX) begin
            r_target_index <= pwdata[7:0];
        end
    end

    qped_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_char         (i_in_char),
        .i_last         (i_in_last),
        .i_target_index (r_target_index),
        .i_qstat        (qstat),
        .o_stall        (o_in_stall),
        .o_push         (push),
        .o_job          (front_job)
    );

    qped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    qped_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_qstat (qstat),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_kind  (o_item_kind),
        .o_byte  (o_out_byte),
        .o_found (o_param_found),
        .o_last  (o_out_last)
    );

    `QPED_ASSERT_ALWAYS(a_reset_clears_output, !i_rst_n |=> !o_out_valid)
    `QPED_ASSERT(a_last_is_end, (o_out_valid && o_out_last) |-> (o_item_kind == KIND_END && o_out_byte == 8'h00))
    `QPED_ASSERT(a_byte_item_clean, (o_out_valid && !o_out_last) |-> (!o_param_found && o_item_kind != KIND_END))
    `QPED_ASSERT(a_no_push_when_full, qstat.full |-> !(push && !pop))

endmodule

[rtl/qped_front.sv]
// Front end: accepts raw bytes, tracks escapes and segments, and queues results.
// Depends on qped_pkg.
module qped_front
    import qped_pkg::*;
#(
    parameter int INDEX_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic [7:0] i_target_index,
    input  t_qstat     i_qstat,
    output logic       o_stall,
    output logic       o_push,
    output t_job       o_job
);

    localparam int CMP_W = (INDEX_BITS > 8) ? INDEX_BITS : 8;

    t_esc                  r_esc, n_esc;
    logic [4:0]            r_high, n_high;
    logic [INDEX_BITS-1:0] r_seg, n_seg;
    logic                  r_val_part, n_val_part;
    logic                  r_seen, n_seen;

    logic       accept;
    logic       is_target;
    logic       emit;
    logic [7:0] dec_byte;
    logic [4:0] low;

    assign o_stall   = i_qstat.full;
    assign accept    = i_valid && !i_qstat.full;
    assign is_target = (CMP_W'(r_seg) == CMP_W'(i_target_index));

    always_comb begin
        n_esc      = r_esc;
        n_high     = r_high;
        n_seg      = r_seg;
        n_val_part = r_val_part;
        n_seen     = r_seen;
        emit       = 1'b0;
        dec_byte   = 8'h00;
        low        = hex_value(i_char);
        if (accept) begin
            n_seen = r_seen || is_target;
            if (i_char == CH_AMP) begin
                n_esc      = ESC_IDLE;
                n_high     = 5'd0;
                n_val_part = 1'b0;
                if (r_seg != {INDEX_BITS{1'b1}}) begin
                    n_seg = r_seg + 1'b1;
                end
            end else if (i_char == CH_EQ && !r_val_part) begin
                n_esc      = ESC_IDLE;
                n_high     = 5'd0;
                n_val_part = 1'b1;
            end else begin
                case (r_esc)
                    ESC_HIGH: begin
                        n_high = low;
                        n_esc  = ESC_LOW;
                    end
                    ESC_LOW: begin
                        emit     = !low[4] && !r_high[4];
                        dec_byte = {r_high[3:0], low[3:0]};
                        n_esc    = ESC_IDLE;
                        n_high   = 5'd0;
                    end
                    default: begin
                        if (i_char == CH_PCT) begin
                            n_esc  = ESC_HIGH;
                            n_high = 5'd0;
                        end else begin
                            n_esc    = ESC_IDLE;
                            emit     = 1'b1;
                            dec_byte = (i_char == CH_PLUS) ? CH_SPACE : i_char;
                        end
                    end
                endcase
            end
            if (i_last) begin
                n_esc      = ESC_IDLE;
                n_high     = 5'd0;
                n_seg      = '0;
                n_val_part = 1'b0;
                n_seen     = 1'b0;
            end
        end
    end

    always_comb begin
        o_push         = accept && ((emit && is_target) || i_last);
        o_job.has_byte = emit && is_target;
        o_job.kind     = r_val_part ? KIND_VALUE : KIND_NAME;
        o_job.data     = dec_byte;
        o_job.has_end  = i_last;
        o_job.found    = r_seen || is_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= ESC_IDLE;
            r_high     <= 5'd0;
            r_seg      <= '0;
            r_val_part <= 1'b0;
            r_seen     <= 1'b0;
        end else begin
            r_esc      <= n_esc;
            r_high     <= n_high;
            r_seg      <= n_seg;
            r_val_part <= n_val_part;
            r_seen     <= n_seen;
        end
    end

endmodule

[rtl/qped_queue.sv]
// Short queue of pending result jobs between the front and back ends.
// Depends on qped_pkg.
module qped_queue
    import qped_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    logic do_push;
    logic do_pop;

    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_job         = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/qped_back.sv]
// Back end: pops queued jobs and presents their result items one per cycle while not stalled.
// Depends on qped_pkg.
module qped_back
    import qped_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte,
    output logic       o_found,
    output logic       o_last
);

    logic       r_valid, n_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic       r_found, n_found;
    logic       r_last, n_last;
    logic       r_end_pend, n_end_pend;
    logic       r_end_found, n_end_found;

    logic take;

    assign take = !r_valid || !i_stall;

    always_comb begin
        n_valid     = r_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_found     = r_found;
        n_last      = r_last;
        n_end_pend  = r_end_pend;
        n_end_found = r_end_found;
        o_pop       = 1'b0;
        if (take) begin
            n_valid = 1'b0;
            if (r_end_pend) begin
                n_valid    = 1'b1;
                n_kind     = KIND_END;
                n_byte     = 8'h00;
                n_found    = r_end_found;
                n_last     = 1'b1;
                n_end_pend = 1'b0;
            end else if (!i_qstat.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_job.has_byte) begin
                    n_kind      = i_job.kind;
                    n_byte      = i_job.data;
                    n_found     = 1'b0;
                    n_last      = 1'b0;
                    n_end_pend  = i_job.has_end;
                    n_end_found = i_job.found;
                end else begin
                    n_kind  = KIND_END;
                    n_byte  = 8'h00;
                    n_found = i_job.found;
                    n_last  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_end_pend <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_end_pend <= n_end_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_byte      <= n_byte;
        r_found     <= n_found;
        r_last      <= n_last;
        r_end_found <= n_end_found;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_found = r_found;
    assign o_last  = r_last;

endmodule

[sim/tb_query_param_extract_decode.sv]
// Self-checking testbench for query_param_extract_decode: query bytes in, decoded bytes out.
// Depends on qped_pkg and the RTL of the block; a built-in predictor checks every result.
`timescale 1ns / 100ps

module tb_query_param_extract_decode;
    import qped_pkg::*;

    localparam int INDEX_BITS = 8;
    localparam logic [INDEX_BITS-1:0] SEG_MAX = '1;
    localparam logic [2:0] REG_TARGET_INDEX = 3'd0;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum {GAPS_NONE, GAPS_SEND, GAPS_RECV, GAPS_BOTH} t_gaps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_query_byte;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       found;
        logic       last;
    } t_decoded_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_char = '0;
    logic        i_in_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_item_kind;
    logic [7:0]  o_out_byte;
    logic        o_param_found;
    logic        o_out_last;

    t_query_byte   query_bytes_q[$];
    t_decoded_item decoded_items_q[$];
    int            bytes_queued = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            send_gap_pct = 0;
    int            stall_pct = 0;
    logic          in_fire = 1'b0;

    logic [7:0]            cfg_target = '0;
    t_esc                  esc_state = ESC_IDLE;
    logic [4:0]            esc_high = '0;
    logic [INDEX_BITS-1:0] seg_count = '0;
    logic                  in_value = 1'b0;
    logic                  target_hit = 1'b0;

    query_param_extract_decode #(
        .INDEX_BITS(INDEX_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_char(i_in_char),
        .i_in_last(i_in_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_item_kind(o_item_kind),
        .o_out_byte(o_out_byte),
        .o_param_found(o_param_found),
        .o_out_last(o_out_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]}) begin
            return {1'b0, c[3:0]};
        end
        if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic clear_decode_state();
        esc_state = ESC_IDLE;
        esc_high = '0;
        seg_count = '0;
        in_value = 1'b0;
        target_hit = 1'b0;
    endtask

    task automatic decode_query_byte(input logic [7:0] c, input logic last);
        logic       hit;
        logic       emit;
        logic [7:0] dec;
        logic [4:0] low;
        hit = (seg_count == cfg_target);
        emit = 1'b0;
        dec = '0;
        if (hit) begin
            target_hit = 1'b1;
        end
        if (c == CH_AMP) begin
            esc_state = ESC_IDLE;
            esc_high = '0;
            in_value = 1'b0;
            if (seg_count != SEG_MAX) begin
                seg_count = seg_count + 1'b1;
            end
        end else if (c == CH_EQ && !in_value) begin
            esc_state = ESC_IDLE;
            esc_high = '0;
            in_value = 1'b1;
        end else if (esc_state == ESC_HIGH) begin
            esc_high = hex_digit(c);
            esc_state = ESC_LOW;
        end else if (esc_state == ESC_LOW) begin
            low = hex_digit(c);
            if (!low[4] && !esc_high[4]) begin
                emit = 1'b1;
                dec = {esc_high[3:0], low[3:0]};
            end
            esc_state = ESC_IDLE;
            esc_high = '0;
        end else if (c == CH_PCT) begin
            esc_state = ESC_HIGH;
            esc_high = '0;
        end else begin
            esc_state = ESC_IDLE;
            emit = 1'b1;
            dec = (c == CH_PLUS) ? CH_SPACE : c;
        end
        if (emit && hit) begin
            decoded_items_q.push_back('{in_value ? KIND_VALUE : KIND_NAME, dec, 1'b0, 1'b0});
        end
        if (last) begin
            decoded_items_q.push_back('{KIND_END, 8'h00, target_hit, 1'b1});
            clear_decode_state();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_decoded_item want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("query_param_extract_decode regression: fail");
            $finish;
        end
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            cfg_target = '0;
            clear_decode_state();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_TARGET_INDEX) begin
                cfg_target = pwdata[7:0];
            end
            if (o_out_valid && !i_out_stall) begin
                if (decoded_items_q.size() == 0) begin
                    report_mismatch("result without expectation", {o_item_kind, o_out_byte}, 0);
                end else begin
                    want = decoded_items_q.pop_front();
                    if (o_item_kind !== want.kind) begin
                        report_mismatch("item_kind", o_item_kind, want.kind);
                    end
                    if (o_out_byte !== want.data) begin
                        report_mismatch("out_byte", o_out_byte, want.data);
                    end
                    if (o_param_found !== want.found) begin
                        report_mismatch("param_found", o_param_found, want.found);
                    end
                    if (o_out_last !== want.last) begin
                        report_mismatch("out_last", o_out_last, want.last);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                decode_query_byte(i_in_char, i_in_last);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_query_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (!i_in_valid || in_fire) begin
                if (query_bytes_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = query_bytes_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_char <= nxt.ch;
                    i_in_last <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic set_gaps(input t_gaps mode);
        case (mode)
            GAPS_NONE: begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            GAPS_SEND: begin
                send_gap_pct = 82;
                stall_pct = 0;
            end
            GAPS_RECV: begin
                send_gap_pct = 0;
                stall_pct = 82;
            end
            default: begin
                send_gap_pct = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    task automatic reg_write(input logic [7:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TARGET_INDEX;
        pwdata <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] !== val) begin
            report_mismatch("target_index readback", prdata, val);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] c);
        query_bytes_q.push_back('{c, 1'b0});
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task automatic mark_last();
        int idx;
        idx = query_bytes_q.size() - 1;
        query_bytes_q[idx] = '{query_bytes_q[idx].ch, 1'b1};
    endtask

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(2))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return 8'h61 + 8'($urandom_range(5));
            default: return 8'h41 + 8'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        logic [4:0] d;
        c = 8'($urandom_range(255));
        d = hex_digit(c);
        while (!d[4] || c == CH_AMP) begin
            c = 8'($urandom_range(255));
            d = hex_digit(c);
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(2))
            0: return 8'h61 + 8'($urandom_range(25));
            1: return 8'h41 + 8'($urandom_range(25));
            default: return 8'h30 + 8'($urandom_range(9));
        endcase
    endfunction

    task automatic gen_part(input int len);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                push_byte(rand_alnum());
            end else if (r < 50) begin
                push_byte(CH_PLUS);
            end else if (r < 65) begin
                push_byte(CH_PCT);
                push_byte(rand_hex());
                push_byte(rand_hex());
            end else if (r < 70) begin
                push_byte(CH_PCT);
                push_byte(rand_nonhex());
                push_byte(rand_hex());
            end else if (r < 74) begin
                push_byte(CH_PCT);
                push_byte(rand_hex());
                push_byte(rand_nonhex());
            end else if (r < 78) begin
                push_byte(CH_PCT);
                if ($urandom_range(1) != 0) begin
                    push_byte(rand_hex());
                end
                break;
            end else if (r < 88) begin
                push_byte(8'($urandom_range(255)));
            end else begin
                push_byte(CH_EQ);
            end
        end
    endtask

    task automatic gen_string(input int max_params);
        int start;
        int np;
        start = bytes_queued;
        np = $urandom_range(1, max_params);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
        end else begin
            for (int p = 0; p < np; p++) begin
                if (p > 0) begin
                    push_byte(CH_AMP);
                end
                gen_part($urandom_range(0, 4));
                if ($urandom_range(4) != 0) begin
                    push_byte(CH_EQ);
                    gen_part($urandom_range(0, 5));
                end
            end
            if ($urandom_range(7) == 0) begin
                push_byte(CH_AMP);
            end
        end
        if (bytes_queued == start) begin
            push_byte(rand_alnum());
        end
        mark_last();
    endtask

    task automatic wait_drained();
        while (query_bytes_q.size() != 0 || i_in_valid || decoded_items_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [7:0] targets [8];
        int         phase_start;
        targets = '{8'd1, 8'd0, 8'd2, SEG_MAX, 8'd3, 8'd0, 8'd1, 8'd0};
        targets[5] = 8'($urandom_range(5));
        set_gaps(GAPS_NONE);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_text("a+%41%z1=%6==%4&q");
        push_byte(8'hFF);
        mark_last();
        push_byte(8'h00);
        mark_last();
        push_byte(CH_PCT);
        mark_last();
        push_text("%4=%Af");
        mark_last();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        for (int ph = 0; ph < 8; ph++) begin
            set_gaps(t_gaps'(ph % 4));
            reg_write(targets[ph]);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 58) gen_string(6);
            wait_drained();
            while (bytes_queued - phase_start < 115) gen_string(6);
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end

        set_gaps(GAPS_BOTH);
        reg_write(SEG_MAX);
        repeat (252) push_byte(CH_AMP);
        for (int p = 0; p < 8; p++) begin
            push_byte(CH_AMP);
            gen_part(3);
            push_byte(CH_EQ);
            gen_part(3);
        end
        mark_last();
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (decoded_items_q.size() != 0) begin
            report_mismatch("expected results left over", decoded_items_q.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("query_param_extract_decode regression: pass");
        end else begin
            $display("query_param_extract_decode regression: fail");
        end
        $finish;
    end

endmodule
